@@ design/cp0t_pkg.sv @@
// Shared types and constants for the CP0 timer and exception-return slice.
package cp0t_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned ActionW  = 4;
  localparam int unsigned TicksW   = 16;
  localparam int unsigned ShiftW   = 5;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 5;
  localparam int unsigned AsidW    = 8;

  localparam logic [ShiftW-1:0] PageShiftReset = 5'd12;

  localparam int unsigned StatusExlBit = 1;
  localparam int unsigned StatusErlBit = 2;

  typedef enum logic [ActionW-1:0] {
    ActTick       = 4'd0,
    ActWrCount    = 4'd1,
    ActWrCompare  = 4'd2,
    ActWrEntryHi  = 4'd3,
    ActWrStatus   = 4'd4,
    ActWrEpc      = 4'd5,
    ActWrErrorEpc = 4'd6,
    ActEret       = 4'd7,
    ActRfe        = 4'd8
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPageShift = 1'b0,
    CfgIsaSplit  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [DataW-1:0] count_now;
    logic             timer_irq;
    logic [DataW-1:0] status_now;
    logic [DataW-1:0] entryhi_now;
    logic             jump_valid;
    logic [DataW-1:0] next_pc;
    logic             ret_mode;
    logic             asid_flush;
    logic             clear_link;
  } result_t;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [DataW-1:0]   value;
    logic [TicksW-1:0]  ticks;
  } request_t;

endpackage

@@ design/cp0t_if.sv @@
// Request and result channel interfaces for the CP0 timer slice.
interface cp0t_req_if;
  logic                              valid;
  logic                              ready;
  logic [cp0t_pkg::ActionW-1:0]      action;
  logic [cp0t_pkg::DataW-1:0]        value;
  logic [cp0t_pkg::TicksW-1:0]       ticks;

  modport source (output valid, action, value, ticks, input ready);
  modport sink   (input valid, action, value, ticks, output ready);
endinterface

interface cp0t_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [cp0t_pkg::DataW-1:0]        count_now;
  logic                              timer_irq;
  logic [cp0t_pkg::DataW-1:0]        status_now;
  logic [cp0t_pkg::DataW-1:0]        entryhi_now;
  logic                              jump_valid;
  logic [cp0t_pkg::DataW-1:0]        next_pc;
  logic                              ret_mode;
  logic                              asid_flush;
  logic                              clear_link;

  modport source (output valid, count_now, timer_irq, status_now, entryhi_now, jump_valid,
                  next_pc, ret_mode, asid_flush, clear_link, input ready);
  modport sink   (input valid, count_now, timer_irq, status_now, entryhi_now, jump_valid,
                  next_pc, ret_mode, asid_flush, clear_link, output ready);
endinterface

@@ design/cp0_timer_and_exception_return.sv @@
// An accepted request moves from the input register to the result register once the
// latter is empty or read. Throughput: one request per cycle unless the output stalls;
// the input and result registers hold one request each, and stalls cost no bubbles.
// The update of Count, Compare, Status, EntryHi and the ERET target is one pass of
// logic between those registers; the Count add and sign test set the path.
// Reset clears every CP0 register, disarms the timer and restores the page shift to 12.
module cp0_timer_and_exception_return (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  cp0t_req_if.sink                        req_i,
  cp0t_rsp_if.source                      rsp_o,
  input  logic                            cfg_we_i,
  input  logic [cp0t_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [cp0t_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  // configuration
  logic [cp0t_pkg::ShiftW-1:0] page_shift_q;
  logic                        isa_split_q;

  // input stage
  logic                s1_valid_q;
  cp0t_pkg::request_t  s1_req_q;
  logic                s1_fire;

  // result stage
  logic                out_valid_q;
  cp0t_pkg::result_t   res_q, res_d;

  // architectural state
  logic [cp0t_pkg::DataW-1:0] count_q, count_d;
  logic [cp0t_pkg::DataW-1:0] compare_q, compare_d;
  logic                       armed_q, armed_d;
  logic                       pend_q, pend_d;
  logic [cp0t_pkg::DataW-1:0] status_q, status_d;
  logic [cp0t_pkg::DataW-1:0] entryhi_q, entryhi_d;
  logic [cp0t_pkg::DataW-1:0] epc_q, epc_d;
  logic [cp0t_pkg::DataW-1:0] errorepc_q, errorepc_d;

  logic [cp0t_pkg::DataW-1:0] count_tick, diff, hi_mask, pc_raw;
  logic [cp0t_pkg::ShiftW:0]  mask_shamt;

  assign s1_fire     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q <= cp0t_pkg::PageShiftReset;
      isa_split_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cp0t_pkg::cfg_idx_e'(cfg_index_i))
        cp0t_pkg::CfgPageShift: page_shift_q <= cfg_wdata_i[cp0t_pkg::ShiftW-1:0];
        cp0t_pkg::CfgIsaSplit:  isa_split_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      s1_req_q.action <= req_i.action;
      s1_req_q.value  <= req_i.value;
      s1_req_q.ticks  <= req_i.ticks;
    end
  end

  // Shared terms of the single update pass
  assign count_tick = count_q + {{(cp0t_pkg::DataW-cp0t_pkg::TicksW){1'b0}}, s1_req_q.ticks};
  assign diff       = count_tick - compare_q;
  assign mask_shamt = {1'b0, page_shift_q} + {{cp0t_pkg::ShiftW{1'b0}}, 1'b1};
  // a shift of 32 empties the VPN2 field and leaves only the ASID
  assign hi_mask    = ({cp0t_pkg::DataW{1'b1}} << mask_shamt)
                      | {{(cp0t_pkg::DataW-cp0t_pkg::AsidW){1'b0}}, {cp0t_pkg::AsidW{1'b1}}};
  assign pc_raw     = status_q[cp0t_pkg::StatusErlBit] ? errorepc_q : epc_q;

  always_comb begin
    count_d    = count_q;
    compare_d  = compare_q;
    armed_d    = armed_q;
    pend_d     = pend_q;
    status_d   = status_q;
    entryhi_d  = entryhi_q;
    epc_d      = epc_q;
    errorepc_d = errorepc_q;
    res_d      = '0;

    unique case (s1_req_q.action)
      cp0t_pkg::ActTick: begin
        count_d = count_tick;
        if (armed_q && !diff[cp0t_pkg::DataW-1]) begin
          pend_d  = 1'b1;
          armed_d = 1'b0;
        end
      end
      cp0t_pkg::ActWrCount: count_d = s1_req_q.value;
      cp0t_pkg::ActWrCompare: begin
        compare_d = s1_req_q.value;
        pend_d    = 1'b0;
        armed_d   = 1'b1;
      end
      cp0t_pkg::ActWrEntryHi: begin
        entryhi_d = (s1_req_q.value & hi_mask) | (entryhi_q & ~hi_mask);
        res_d.asid_flush = entryhi_d[cp0t_pkg::AsidW-1:0] != entryhi_q[cp0t_pkg::AsidW-1:0];
      end
      cp0t_pkg::ActWrStatus:   status_d   = s1_req_q.value;
      cp0t_pkg::ActWrEpc:      epc_d      = s1_req_q.value;
      cp0t_pkg::ActWrErrorEpc: errorepc_d = s1_req_q.value;
      cp0t_pkg::ActEret: begin
        if (status_q[cp0t_pkg::StatusErlBit]) begin
          status_d[cp0t_pkg::StatusErlBit] = 1'b0;
        end else begin
          status_d[cp0t_pkg::StatusExlBit] = 1'b0;
        end
        res_d.jump_valid = 1'b1;
        res_d.clear_link = 1'b1;
        res_d.next_pc    = pc_raw;
        if (isa_split_q) begin
          res_d.ret_mode   = pc_raw[0];
          res_d.next_pc[0] = 1'b0;
        end
      end
      // pop the IE/KU stack by one level
      cp0t_pkg::ActRfe: status_d[3:0] = status_q[5:2];
      default: ;
    endcase

    res_d.count_now   = count_d;
    res_d.timer_irq   = pend_d;
    res_d.status_now  = status_d;
    res_d.entryhi_now = entryhi_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      compare_q  <= '0;
      armed_q    <= 1'b0;
      pend_q     <= 1'b0;
      status_q   <= '0;
      entryhi_q  <= '0;
      epc_q      <= '0;
      errorepc_q <= '0;
    end else if (s1_fire) begin
      count_q    <= count_d;
      compare_q  <= compare_d;
      armed_q    <= armed_d;
      pend_q     <= pend_d;
      status_q   <= status_d;
      entryhi_q  <= entryhi_d;
      epc_q      <= epc_d;
      errorepc_q <= errorepc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || rsp_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.count_now   = res_q.count_now;
  assign rsp_o.timer_irq   = res_q.timer_irq;
  assign rsp_o.status_now  = res_q.status_now;
  assign rsp_o.entryhi_now = res_q.entryhi_now;
  assign rsp_o.jump_valid  = res_q.jump_valid;
  assign rsp_o.next_pc     = res_q.next_pc;
  assign rsp_o.ret_mode    = res_q.ret_mode;
  assign rsp_o.asid_flush  = res_q.asid_flush;
  assign rsp_o.clear_link  = res_q.clear_link;

`ifndef SYNTH
  a_pend_armed_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pend_q && armed_q))
    else $error("timer both pending and armed");

  a_compare_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (s1_req_q.action == cp0t_pkg::ActWrCompare) |=> armed_q && !pend_q)
    else $error("compare write did not re-arm timer");

  a_no_jump_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.jump_valid |-> (res_q.next_pc == '0) && !res_q.ret_mode
                                         && !res_q.clear_link)
    else $error("eret outputs set without jump");

  a_isa_needs_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.ret_mode |-> isa_split_q && !res_q.next_pc[0])
    else $error("isa mode reported without split enabled");

  a_stage_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("request lost between stages");
`endif

endmodule
